FILE: hw/rtl/fsp_pkg.sv
// Package with shared types, register codes and pattern helpers for the substring search.
`default_nettype none

package fsp_pkg;

  // Number of pattern bytes held in the two pattern registers.
  localparam int PATTERN_REG_BYTES = 16;

  // Saturation value of the byte counter, also the position reported when nothing matched.
  localparam logic [7:0] COUNT_MAX = 8'hFF;
  localparam logic [7:0] NO_MATCH  = 8'hFF;

  // Register index codes, taken from paddr[4:3].
  localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [1:0] REG_PATTERN_LEN  = 2'd2;

  // One text byte transaction.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_t;

  // One result transaction.
  typedef struct packed {
    logic       match_found;
    logic [7:0] match_position;
  } result_t;

  // Configuration handed from the register block to the search logic.
  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [4:0]  pattern_length;
  } cfg_t;

  // Pattern byte k; bytes past the register pair read as zero.
  function automatic logic [7:0] pattern_at(input cfg_t cfg, input logic [4:0] k);
    logic [7:0] b;
    b = 8'h00;
    if (k < 5'd8) begin
      b = cfg.pattern_low[{k[2:0], 3'b000} +: 8];
    end else if (k < 5'd16) begin
      b = cfg.pattern_high[{k[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  // Number of leading pattern bytes that take part in a compare. The compare
  // stops with success at the first zero pattern byte, so the effective length
  // is the configured length cut at one past that zero.
  function automatic logic [4:0] compare_length(input cfg_t cfg);
    logic [4:0] zero_at;
    logic       seen;
    zero_at = 5'(PATTERN_REG_BYTES);
    seen    = 1'b0;
    for (int k = 0; k < PATTERN_REG_BYTES; k++) begin
      if (!seen && pattern_at(cfg, 5'(k)) == 8'h00) begin
        zero_at = 5'(k);
        seen    = 1'b1;
      end
    end
    return (cfg.pattern_length > zero_at) ? 5'(zero_at + 5'd1) : cfg.pattern_length;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fsp_cell.sv
// One window cell: holds a text byte, passes it on and compares the byte it takes in.
`default_nettype none

module fsp_cell (
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] pattern_byte,
  input  wire logic       in_use,
  output logic      [7:0] byte_out,
  output logic            ok
);

  logic [7:0] held;

  // Window storage moves one place toward the older end on each accepted byte.
  always_ff @(posedge clk) begin
    if (shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;

  // The compare looks at the value this cell holds after the shift.
  assign ok = !in_use || (byte_in == pattern_byte);

endmodule

`default_nettype wire

FILE: hw/rtl/fsp_regs.sv
// APB register block holding the pattern bytes and pattern length.
`default_nettype none

module fsp_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output fsp_pkg::cfg_t    cfg
);

  fsp_pkg::cfg_t regs;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes land at the end of the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:3])
        fsp_pkg::REG_PATTERN_LOW:  regs.pattern_low    <= pwdata;
        fsp_pkg::REG_PATTERN_HIGH: regs.pattern_high   <= pwdata;
        fsp_pkg::REG_PATTERN_LEN:  regs.pattern_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    unique case (paddr[4:3])
      fsp_pkg::REG_PATTERN_LOW:  prdata = regs.pattern_low;
      fsp_pkg::REG_PATTERN_HIGH: prdata = regs.pattern_high;
      fsp_pkg::REG_PATTERN_LEN:  prdata = {59'd0, regs.pattern_length};
      default:                   prdata = 64'd0;
    endcase
  end

  assign cfg = regs;

endmodule

`default_nettype wire

FILE: hw/rtl/first_substring_position.sv
// Top level of the streaming first-substring-position search.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------
//   text     | text_valid / text_ready      | text_t   (text_byte, last_byte)
//   result   | result_valid / result_ready  | result_t (match_found, position)
//   config   | APB psel/penable/pwrite      | 64-bit registers at 0, 8, 16
//
// One text byte is taken per cycle while the output register is empty or is
// being emptied; the row of window cells compares the shifted window with the
// pattern in the same cycle the byte is accepted. The result of a text appears
// in the cycle after its last byte is accepted and sits in the output register
// until taken. Synchronous reset clears the counters, the match state, the
// output register and the configuration registers.
`default_nettype none

module first_substring_position #(
  parameter int PATTERN_MAX = 16,
  parameter int TEXT_LIMIT  = 255
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             text_valid,
  output logic                  text_ready,
  input  wire fsp_pkg::text_t   text,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output fsp_pkg::result_t      result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic      [63:0]      prdata,
  output logic                  pready
);

  // Wide enough for a cell index plus a pattern length.
  localparam int SUM_W = $clog2(PATTERN_MAX + 32);

  fsp_pkg::cfg_t    cfg;
  logic [4:0]       cmp_len;
  logic             len_ok;
  logic             accept;
  logic [7:0]       bytes_seen;
  logic [7:0]       bytes_seen_next;
  logic [7:0]       first_start;
  logic             have_match;
  logic             window_hit;
  logic             new_match;
  logic             have_match_next;
  logic [7:0]       first_start_next;
  logic             found;
  fsp_pkg::result_t result_next;

  logic [7:0] cell_byte [PATTERN_MAX];
  logic [7:0] cell_in   [PATTERN_MAX];
  logic [7:0] cell_pat  [PATTERN_MAX];
  logic       cell_use  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_ok;

  fsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign cmp_len = fsp_pkg::compare_length(cfg);
  assign len_ok  = (cfg.pattern_length != 5'd0) &&
                   (SUM_W'(cfg.pattern_length) <= SUM_W'(PATTERN_MAX));

  assign text_ready = !result_valid || result_ready;
  assign accept     = text_valid && text_ready;

  // Row of window cells; the newest byte enters at the top cell.
  for (genvar w = 0; w < PATTERN_MAX; w++) begin : g_cell
    logic [SUM_W-1:0] pos;
    logic [SUM_W-1:0] k;

    assign pos = SUM_W'(w) + SUM_W'(cfg.pattern_length);
    assign k   = pos - SUM_W'(PATTERN_MAX);

    // Cell w lines up with pattern byte w + length - PATTERN_MAX.
    assign cell_use[w] = (pos >= SUM_W'(PATTERN_MAX)) &&
                         (pos < SUM_W'(PATTERN_MAX) + SUM_W'(cmp_len));
    assign cell_pat[w] = fsp_pkg::pattern_at(cfg, k[4:0]);

    if (w == PATTERN_MAX - 1) begin : g_top
      assign cell_in[w] = text.text_byte;
    end else begin : g_mid
      assign cell_in[w] = cell_byte[w+1];
    end

    fsp_cell u_cell (
      .clk          (clk),
      .shift        (accept),
      .byte_in      (cell_in[w]),
      .pattern_byte (cell_pat[w]),
      .in_use       (cell_use[w]),
      .byte_out     (cell_byte[w]),
      .ok           (cell_ok[w])
    );
  end

  assign window_hit = &cell_ok;

  // Byte count and first match for the text in progress.
  always_comb begin
    bytes_seen_next  = bytes_seen;
    new_match        = 1'b0;
    if (bytes_seen != fsp_pkg::COUNT_MAX) begin
      bytes_seen_next = bytes_seen + 8'd1;
      new_match = !have_match && len_ok && window_hit &&
                  (bytes_seen_next >= {3'd0, cfg.pattern_length});
    end
    have_match_next  = have_match || new_match;
    first_start_next = new_match ? (bytes_seen_next - {3'd0, cfg.pattern_length})
                                 : first_start;
    found = have_match_next && len_ok && (bytes_seen_next < 8'(TEXT_LIMIT));
    result_next.match_found    = found;
    result_next.match_position = found ? first_start_next : fsp_pkg::NO_MATCH;
  end

  // Per-text state clears after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= 8'd0;
      first_start <= 8'd0;
      have_match  <= 1'b0;
    end else if (accept) begin
      if (text.last_byte) begin
        bytes_seen  <= 8'd0;
        first_start <= 8'd0;
        have_match  <= 1'b0;
      end else begin
        bytes_seen  <= bytes_seen_next;
        first_start <= first_start_next;
        have_match  <= have_match_next;
      end
    end
  end

  // Output register holding one result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && text.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.last_byte) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fsp_checker.sv
// Port-level checks on the substring search, bound to the top level.
`default_nettype none

module fsp_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             text_valid,
  input wire logic             text_ready,
  input wire fsp_pkg::text_t   text,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire fsp_pkg::result_t result,
  input wire logic             pready
);

  // A result without a match always reports the no-match position.
  a_nomatch_pos: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.match_found) |-> (result.match_position == fsp_pkg::NO_MATCH))
    else $error("no-match result carries a position");

  // A new result only follows a transaction that ended a text.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(text_valid && text_ready && text.last_byte))
    else $error("result without a last text byte");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // Reset empties the output register and the config port never stalls.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && pready))
    else $error("output not empty after reset");

endmodule

bind first_substring_position fsp_checker u_fsp_checker (.*);

`default_nettype wire

FILE: dv/fsp_checker.sv
// Checker that predicts substring search results from observed transactions and compares them.
module fsp_scoreboard (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  input  logic             text_ready,
  input  fsp_pkg::text_t   text,
  input  logic             result_valid,
  input  logic             result_ready,
  input  fsp_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [4:0]       paddr,
  input  logic [63:0]      pwdata,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_BYTES = 16;
  localparam int COUNT_LIMIT  = 255;
  localparam int TOO_LONG     = 255;

  // Shadow copy of the configuration registers.
  logic [127:0] pattern_bits;
  logic [4:0]   pattern_len;

  // Per-string search state.
  logic [7:0] window [WINDOW_BYTES];
  int         bytes_so_far;
  int         first_hit;
  bit         hit_seen;

  // Results predicted but not yet delivered by the block, oldest first.
  fsp_pkg::result_t expected_results[$];

  function automatic void clear_text_state();
    for (int i = 0; i < WINDOW_BYTES; i++) window[i] = 8'h00;
    bytes_so_far = 0;
    first_hit    = 0;
    hit_seen     = 1'b0;
  endfunction

  // Shift one text byte in, look for the first occurrence, and predict the
  // result when the byte closes the string.
  task automatic advance_search(input fsp_pkg::text_t item);
    int               len;
    bit               equal;
    bit               stop;
    logic [7:0]       pbyte;
    fsp_pkg::result_t outcome;
    for (int i = 0; i < WINDOW_BYTES - 1; i++) window[i] = window[i + 1];
    window[WINDOW_BYTES - 1] = item.text_byte;
    len = int'(pattern_len);

    // The byte count saturates; once saturated the search stops.
    if (bytes_so_far < COUNT_LIMIT) begin
      bytes_so_far++;
      if (!hit_seen && len != 0 && len <= WINDOW_BYTES && bytes_so_far >= len) begin
        equal = 1'b1;
        stop  = 1'b0;
        // The compare ends early with success where both sides hold a zero byte.
        for (int k = 0; k < len; k++) begin
          pbyte = pattern_bits[8*k +: 8];
          if (!stop) begin
            if (window[WINDOW_BYTES - len + k] != pbyte) begin
              equal = 1'b0;
              stop  = 1'b1;
            end else if (pbyte == 8'h00) begin
              stop = 1'b1;
            end
          end
        end
        if (equal) begin
          hit_seen  = 1'b1;
          first_hit = bytes_so_far - len;
        end
      end
    end

    if (item.last_byte) begin
      outcome.match_found = hit_seen && len != 0 && len <= WINDOW_BYTES &&
                            bytes_so_far < TOO_LONG;
      outcome.match_position = outcome.match_found ? 8'(first_hit) : fsp_pkg::NO_MATCH;
      expected_results.push_back(outcome);
      clear_text_state();
    end
  endtask

  // Watch the configuration port and both channels at each rising edge.
  always @(posedge clk) begin
    fsp_pkg::result_t want;
    if (rst) begin
      pattern_bits = '0;
      pattern_len  = '0;
      clear_text_state();
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          fsp_pkg::REG_PATTERN_LOW:  pattern_bits[63:0]   = pwdata;
          fsp_pkg::REG_PATTERN_HIGH: pattern_bits[127:64] = pwdata;
          fsp_pkg::REG_PATTERN_LEN:  pattern_len          = pwdata[4:0];
          default: ;
        endcase
      end

      if (text_valid && text_ready) begin
        advance_search(text);
      end

      // Each delivered result transaction is matched against the oldest prediction.
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing predicted: expected none, actual found %0d pos %0d",
                   $time, result.match_found, result.match_position);
        end else begin
          want = expected_results.pop_front();
          if (result.match_found !== want.match_found) begin
            mismatches++;
            $display("%0t: match_found expected %0d actual %0d",
                     $time, want.match_found, result.match_found);
          end
          if (result.match_position !== want.match_position) begin
            mismatches++;
            $display("%0t: match_position expected %0d actual %0d",
                     $time, want.match_position, result.match_position);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: dv/first_substring_position_tb.sv
// Testbench top: drives text strings and pattern settings into the substring search block.
module first_substring_position_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             text_valid   = 1'b0;
  logic             text_ready;
  fsp_pkg::text_t   text         = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  fsp_pkg::result_t result;
  logic             psel         = 1'b0;
  logic             penable      = 1'b0;
  logic             pwrite       = 1'b0;
  logic [4:0]       paddr        = '0;
  logic [63:0]      pwdata       = '0;
  logic [63:0]      prdata;
  logic             pready;
  int               mismatches;
  int               pending;

  // Handshake flags captured at the rising edge, read at the falling edge.
  bit text_taken = 1'b0;
  bit apb_done   = 1'b0;

  bit gaps_on       = 1'b1;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int stall_left    = 0;
  int items_sent    = 0;

  logic [7:0] text_buf[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_substring_position dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text         (text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  fsp_scoreboard search_monitor (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text         (text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always @(posedge clk) begin
    text_taken <= text_valid && text_ready;
    apb_done   <= psel && penable && pwrite && pready;
  end

  // Result side: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES - 1;
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 11) == 0) begin
      result_ready <= 1'b0;
      stall_left   <= $urandom_range(0, 12);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Text bytes lean toward a small alphabet so partial matches are common.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2, 3, 4, 5, 6, 7: return 8'h61 + 8'($urandom_range(0, 2));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic apb_write(input logic [1:0] index, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!apb_done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [127:0] bits, input logic [63:0] len_word);
    apb_write(fsp_pkg::REG_PATTERN_LOW, bits[63:0]);
    apb_write(fsp_pkg::REG_PATTERN_HIGH, bits[127:64]);
    apb_write(fsp_pkg::REG_PATTERN_LEN, len_word);
  endtask

  // Offer one text transaction, with an occasional idle burst first.
  task automatic send_byte(input logic [7:0] value, input logic last);
    fsp_pkg::text_t item;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    item.text_byte = value;
    item.last_byte = last;
    text_valid <= 1'b1;
    text       <= item;
    do @(negedge clk); while (!text_taken);
    items_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_byte(text_buf[i], i == text_buf.size() - 1);
    end
    text_buf.delete();
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // The block is idle once every predicted result has been delivered.
  task automatic wait_idle();
    text_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    logic [127:0] pat;
    int plen;
    int copy_len;
    int body_len;
    int insert_at;
    int target;
    int phase_end;
    bit broken;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A zero pattern length straight after reset never matches.
    send_string("ab");

    // Two-byte pattern; the length word carries junk above its five bits.
    wait_idle();
    load_pattern(128'h6261, 64'hFFFF_FFFF_FFFF_FFE2);
    apb_write(REG_UNUSED, '1);
    send_string("xab");
    send_string("a");
    send_string("abab");

    // A zero byte inside the pattern ends the compare, but the full length must fit.
    wait_idle();
    load_pattern(128'h7A7A7A0061, 64'd5);
    text_buf.push_back(8'h79);
    text_buf.push_back(8'h61);
    text_buf.push_back(8'h00);
    send_text();
    text_buf.push_back(8'h61);
    text_buf.push_back(8'h00);
    text_buf.push_back(8'h71);
    text_buf.push_back(8'h72);
    text_buf.push_back(8'h73);
    send_text();

    // Full-width pattern of all-ones bytes.
    wait_idle();
    load_pattern('1, 64'd16);
    for (int i = 0; i < 16; i++) text_buf.push_back(8'hFF);
    send_text();

    // Lengths beyond the pattern storage never match.
    wait_idle();
    load_pattern(128'h6261, 64'd17);
    send_string("ab");
    wait_idle();
    load_pattern(128'h6261, 64'd31);
    send_string("ab");

    // Random phases, each with its own pattern setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      for (int k = 0; k < 16; k++) pat[8*k +: 8] = pick_byte();
      case (phase)
        0: plen = 16;
        1: plen = 1;
        default: begin
          case ($urandom_range(0, 9))
            0: plen = 0;
            1: plen = 16;
            2: plen = $urandom_range(17, 31);
            3, 4, 5: plen = $urandom_range(1, 3);
            default: plen = $urandom_range(1, 16);
          endcase
        end
      endcase
      load_pattern(pat, 64'(plen));
      gaps_on = !(phase == 4 || phase == PHASES - 1);
      if (phase == 2) hold_requests++;

      // A few phases open with a string at the length boundary.
      target = (phase >= 1 && phase <= 3) ? 253 + phase : 0;
      phase_end = items_sent + PHASE_ITEMS;

      while (items_sent < phase_end) begin
        copy_len = (plen > 16) ? 16 : plen;
        broken = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 3) == 0) begin
          copy_len = 0;
        end else if (broken && copy_len > 0) begin
          copy_len = $urandom_range(0, copy_len - 1);
        end
        body_len  = (target != 0) ? target - copy_len : $urandom_range(0, 14);
        insert_at = broken ? body_len : $urandom_range(0, body_len);

        // A cut-off copy sits at the end, so it cannot fit within the string.
        for (int i = 0; i <= body_len; i++) begin
          if (i == insert_at) begin
            for (int k = 0; k < copy_len; k++) text_buf.push_back(pat[8*k +: 8]);
          end
          if (i < body_len) text_buf.push_back(pick_byte());
        end
        if (text_buf.size() == 0) text_buf.push_back(pick_byte());
        target = 0;
        send_text();
      end
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_cell.sv
hw/rtl/fsp_regs.sv
hw/rtl/first_substring_position.sv
hw/rtl/fsp_checker.sv
dv/fsp_checker.sv
dv/first_substring_position_tb.sv
